### sv/lirc_pkg.sv
// Package of shared types and constants for the linear interpolation rate converter.
package lirc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_STEP = 2'd1;

    // Control flags of one command passed from the front end to the back end
    typedef struct packed {
        logic first;
        logic ovf;
    } t_cmd_ctl;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_LOAD,
        B_DIV,
        B_EMIT
    } t_back_state;

endpackage

### sv/lirc_if.sv
// Valid/ready stream interfaces for the input and output words of the rate converter.
interface lirc_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           end_of_block;

    modport source (output valid, output sample_in, output end_of_block, input ready);
    modport sink   (input valid, input sample_in, input end_of_block, output ready);
endinterface

interface lirc_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           last_of_run;
    logic                           overflow_flag;

    modport source (output valid, output sample_out, output last_of_run,
                    output overflow_flag, input ready);
    modport sink   (input valid, input sample_out, input last_of_run,
                    input overflow_flag, output ready);
endinterface

### sv/lirc_div.sv
// Restoring divider giving one quotient bit per cycle.
module lirc_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

### sv/lirc_fifo.sv
// Small register queue carrying commands from the front end to the back end.
module lirc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wr;
    logic [PTRW-1:0]  r_rd;
    logic [CNTW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + PTRW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + PTRW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

### sv/lirc_front.sv
// Front end: takes input words, tracks block and phase state, queues interpolation commands.
module lirc_front import lirc_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STEP_WIDTH   = 16,
    parameter int MAX_OUTPUTS  = 8,
    localparam int CMD_W = $bits(t_cmd_ctl) + 2 * SAMPLE_WIDTH + 3 * STEP_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [STEP_WIDTH-1:0] i_input_step,
    input  logic [STEP_WIDTH-1:0] i_output_step,
    lirc_in_if.sink               i_in,
    output logic                  o_push,
    output logic [CMD_W-1:0]      o_cmd,
    input  logic                  i_full
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = STEP_WIDTH;
    localparam int PW = TW + 1;
    localparam int OW = PW + $clog2(MAX_OUTPUTS + 1) + 1;

    t_front_state     r_state;
    t_front_state     n_state;
    logic             r_awaiting;
    logic [SW-1:0]    r_prev;
    logic [PW-1:0]    r_phase;

    t_cmd_ctl         r_ctl;
    logic [SW-1:0]    r_cmd_prev;
    logic [SW-1:0]    r_cmd_cur;
    logic [TW-1:0]    r_cmd_phase;
    logic [TW-1:0]    r_cmd_istep;
    logic [TW-1:0]    r_cmd_ostep;

    logic [TW-1:0]    w_istep;
    logic [TW-1:0]    w_ostep;
    logic [OW-1:0]    w_ovf_sum;
    logic             w_ready;
    logic             w_accept;
    logic             w_skip;
    logic             w_div_start;
    logic             w_div_done;
    logic [TW-1:0]    w_div_rem;

    always_comb begin
        w_istep   = (i_input_step == '0) ? TW'(1) : i_input_step;
        w_ostep   = (i_output_step == '0) ? TW'(1) : i_output_step;
        w_accept  = i_in.valid && w_ready;
        w_skip    = !r_awaiting && (r_phase >= {1'b0, w_istep});
        w_ovf_sum = OW'(r_phase) + OW'(MAX_OUTPUTS) * OW'(w_ostep);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    if (r_awaiting) begin
                        n_state = F_PUSH;
                    end else if (!w_skip) begin
                        n_state = F_MOD;
                    end
                end
            end
            F_MOD: begin
                if (w_div_done) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        w_ready     = (r_state == F_IDLE) && i_rst_n;
        o_push      = (r_state == F_PUSH) && !i_full;
        w_div_start = w_accept && !r_awaiting && !w_skip;
    end

    assign i_in.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_awaiting <= 1'b1;
            r_phase    <= '0;
            r_prev     <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_prev     <= i_in.sample_in;
                r_awaiting <= i_in.end_of_block;
                if (r_awaiting) begin
                    r_phase <= PW'(w_ostep);
                end else if (w_skip) begin
                    r_phase <= r_phase - PW'(w_istep);
                end
            end
            // The next output lands (ostep - rem) mod ostep past the current sample
            if ((r_state == F_MOD) && w_div_done) begin
                r_phase <= (w_div_rem == '0) ? '0 : PW'(r_cmd_ostep - w_div_rem);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ctl.first <= r_awaiting;
            r_ctl.ovf   <= !r_awaiting && (w_ovf_sum < OW'(w_istep));
            r_cmd_prev  <= r_prev;
            r_cmd_cur   <= i_in.sample_in;
            r_cmd_phase <= r_phase[TW-1:0];
            r_cmd_istep <= w_istep;
            r_cmd_ostep <= w_ostep;
        end
    end

    lirc_div #(
        .NUM_W (TW),
        .DEN_W (TW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_istep - r_phase[TW-1:0]),
        .i_den   (w_ostep),
        .o_done  (w_div_done),
        .o_quot  (),
        .o_rem   (w_div_rem)
    );

    assign o_cmd = {r_ctl, r_cmd_prev, r_cmd_cur, r_cmd_phase, r_cmd_istep, r_cmd_ostep};

    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == F_MOD))
        else $error("phase divider finished outside the modulo state");

    a_interp_starts_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_awaiting && !w_skip) |=> (r_state == F_MOD))
        else $error("interpolating word did not start the phase update");

    a_first_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_awaiting) |=> ((r_state == F_PUSH) && r_ctl.first))
        else $error("first word of a block not queued as pass-through");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_phase[TW])
        else $error("stored phase exceeds the step range");

endmodule

### sv/lirc_back.sv
// Back end: works through queued commands and produces interpolated output words.
module lirc_back import lirc_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STEP_WIDTH   = 16,
    parameter int MAX_OUTPUTS  = 8,
    localparam int CMD_W = $bits(t_cmd_ctl) + 2 * SAMPLE_WIDTH + 3 * STEP_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_empty,
    output logic             o_pop,
    lirc_out_if.source       o_out
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int TW  = STEP_WIDTH;
    localparam int PRW = SW + 1 + TW;
    localparam int KW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    t_back_state      r_state;
    t_back_state      n_state;

    t_cmd_ctl         w_ctl;
    logic [SW-1:0]    w_c_prev;
    logic [SW-1:0]    w_c_cur;
    logic [TW-1:0]    w_c_phase;
    logic [TW-1:0]    w_c_istep;
    logic [TW-1:0]    w_c_ostep;

    logic [SW:0]      w_diff;
    logic [SW:0]      w_mag;
    logic [TW:0]      w_next_p;
    logic [SW:0]      w_base;
    logic [SW:0]      w_res;
    logic             w_div_start;
    logic             w_div_done;
    logic [PRW-1:0]   w_quot;

    logic [SW-1:0]    r_prev;
    logic             r_neg;
    logic [SW:0]      r_mag;
    logic [TW-1:0]    r_p;
    logic [TW-1:0]    r_istep;
    logic [TW-1:0]    r_ostep;
    logic [KW-1:0]    r_k;
    logic [PRW-1:0]   r_prod;
    logic [SW-1:0]    r_out_sample;
    logic             r_last;
    logic             r_ovf;

    assign {w_ctl, w_c_prev, w_c_cur, w_c_phase, w_c_istep, w_c_ostep} = i_cmd;

    always_comb begin
        w_diff   = {w_c_cur[SW-1], w_c_cur} - {w_c_prev[SW-1], w_c_prev};
        w_mag    = w_diff[SW] ? (~w_diff + (SW+1)'(1)) : w_diff;
        w_next_p = {1'b0, r_p} + {1'b0, r_ostep};
        w_base   = {r_prev[SW-1], r_prev};
        w_res    = r_neg ? (w_base - w_quot[SW:0]) : (w_base + w_quot[SW:0]);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = w_ctl.first ? B_EMIT : B_MUL;
                end
            end
            B_MUL:  n_state = B_LOAD;
            B_LOAD: n_state = B_DIV;
            B_DIV: begin
                if (w_div_done) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (o_out.ready) begin
                    n_state = r_last ? B_IDLE : B_MUL;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop       = (r_state == B_IDLE) && !i_empty;
        w_div_start = (r_state == B_LOAD);
        o_out.valid = (r_state == B_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prev  <= w_c_prev;
            r_neg   <= w_diff[SW];
            r_mag   <= w_mag;
            r_p     <= w_c_phase;
            r_istep <= w_c_istep;
            r_ostep <= w_c_ostep;
            r_k     <= '0;
            if (w_ctl.first) begin
                r_out_sample <= w_c_cur;
                r_last       <= 1'b1;
                r_ovf        <= 1'b0;
            end else begin
                r_ovf <= w_ctl.ovf;
            end
        end
        if (r_state == B_MUL) begin
            r_prod <= r_mag * r_p;
            r_last <= (w_next_p >= {1'b0, r_istep}) || (r_k == KW'(MAX_OUTPUTS - 1));
        end
        if ((r_state == B_DIV) && w_div_done) begin
            r_out_sample <= w_res[SW-1:0];
        end
        if ((r_state == B_EMIT) && o_out.ready && !r_last) begin
            r_p <= w_next_p[TW-1:0];
            r_k <= r_k + KW'(1);
        end
    end

    lirc_div #(
        .NUM_W (PRW),
        .DEN_W (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod),
        .i_den   (r_istep),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_rem   ()
    );

    assign o_out.sample_out    = r_out_sample;
    assign o_out.last_of_run   = r_last;
    assign o_out.overflow_flag = r_ovf;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == B_DIV))
        else $error("interpolation divider finished outside the divide state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> (r_k <= KW'(MAX_OUTPUTS - 1)))
        else $error("output count ran past the per-input maximum");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_EMIT) && o_out.ready && r_last) |=> (r_state == B_IDLE))
        else $error("run continued after its last word");

endmodule

### sv/linear_interp_rate_converter.sv
// Top level of the linear interpolation sample-rate converter.
// Flow: a first sample of a block passes the front end's push state and the command queue
// and is offered from the back end's emit state; each interpolated word goes through the
// back end's multiply, load, divide and emit states, the divide paced by the one-bit-per-cycle
// divider. The front end takes an input word every cycle when no output is due and the word
// does not open a block, and takes no input during the phase update of a word that needs one.
// Reset is synchronous and active low: steps return to one, the next sample starts a block.
module linear_interp_rate_converter import lirc_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STEP_WIDTH   = 16,
    parameter int MAX_OUTPUTS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [STEP_WIDTH-1:0] i_cfg_data,
    lirc_in_if.sink               i_in,
    lirc_out_if.source            o_out
);

    // The command word carries the control flags, both samples, the starting phase
    // and the two steps as they stood when the input word was taken.
    localparam int CMD_W     = $bits(t_cmd_ctl) + 2 * SAMPLE_WIDTH + 3 * STEP_WIDTH;
    localparam int CMD_DEPTH = 2;

    logic [STEP_WIDTH-1:0] r_input_step;
    logic [STEP_WIDTH-1:0] r_output_step;

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    logic [CMD_W-1:0] w_cmd_in;
    logic [CMD_W-1:0] w_cmd_out;

    // Configuration registers. Writes to an index beyond the register list are dropped.
    // A step of zero is treated as one further down, so the registers hold the raw value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_step  <= STEP_WIDTH'(1);
            r_output_step <= STEP_WIDTH'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INPUT_STEP:  r_input_step  <= i_cfg_data;
                CFG_OUTPUT_STEP: r_output_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front end keeps the block state and phase; it hands one command per
    // producing input word to the back end through a short queue, so it can take
    // further input words while the back end is still interpolating.
    lirc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STEP_WIDTH   (STEP_WIDTH),
        .MAX_OUTPUTS  (MAX_OUTPUTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_input_step  (r_input_step),
        .i_output_step (r_output_step),
        .i_in          (i_in),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in),
        .i_full        (w_full)
    );

    lirc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // The back end walks the output grid across the span of one command, forming
    // prev + sign(d) * floor(|d| * phase / input_step) for each due output. The
    // result sits in an output register until the downstream side takes it.
    lirc_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STEP_WIDTH   (STEP_WIDTH),
        .MAX_OUTPUTS  (MAX_OUTPUTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

### verif/linear_interp_rate_converter_test.sv
// Self-checking testbench of the linear interpolation rate converter, with its scoreboard.

class resample_scoreboard #(int SW = 16, int PW = 16, int MAXW = 8);

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 last;
        logic                 ovf;
    } t_word;

    localparam int PRINT_CAP = 100;

    logic [PW-1:0]        in_step;
    logic [PW-1:0]        out_step;
    logic signed [SW-1:0] prev_sample;
    logic [PW:0]          phase;
    bit                   awaiting_first;
    t_word                pending[$];

    int mismatches      = 0;
    int words_in        = 0;
    int words_out       = 0;
    int overflow_inputs = 0;
    int silent_inputs   = 0;
    int blocks          = 0;

    function new();
        in_step        = PW'(1);
        out_step       = PW'(1);
        prev_sample    = '0;
        phase          = '0;
        awaiting_first = 1'b1;
    endfunction

    task report(string msg);
        if (mismatches < PRINT_CAP) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function void set_step(logic [lirc_pkg::CFG_IDX_W-1:0] idx, logic [PW-1:0] value);
        case (idx)
            lirc_pkg::CFG_INPUT_STEP:  in_step = value;
            lirc_pkg::CFG_OUTPUT_STEP: out_step = value;
            default: ;
        endcase
    endfunction

    // Point on the line from one sample to the next, truncated towards the earlier one.
    function logic signed [SW-1:0] blend(longint from_s, longint to_s, longint ph, longint span);
        longint diff, mag, inc;
        diff = to_s - from_s;
        mag  = (diff < 0) ? -diff : diff;
        inc  = (mag / span) * ph + ((mag % span) * ph) / span;
        return SW'((diff < 0) ? from_s - inc : from_s + inc);
    endfunction

    function void note_input(logic signed [SW-1:0] smp, logic eob);
        longint ist, ost, ph, due, emit, k;
        t_word  w;
        ist = longint'(in_step);
        ost = longint'(out_step);
        if (ist == 0) ist = 1;
        if (ost == 0) ost = 1;
        words_in++;
        if (awaiting_first) begin
            w.sample = smp;
            w.last   = 1'b1;
            w.ovf    = 1'b0;
            pending.push_back(w);
            phase          = (PW+1)'(ost);
            awaiting_first = 1'b0;
        end else begin
            ph  = longint'(phase);
            due = 0;
            if (ph < ist) due = (ist - ph - 1) / ost + 1;
            emit = (due > MAXW) ? MAXW : due;
            for (k = 0; k < emit; k++) begin
                w.sample = blend(longint'(prev_sample), longint'(smp), ph + k * ost, ist);
                w.last   = (k + 1 == emit);
                w.ovf    = (due > MAXW);
                pending.push_back(w);
            end
            if (due == 0) silent_inputs++;
            if (due > MAXW) overflow_inputs++;
            phase = (PW+1)'(ph + due * ost - ist);
        end
        prev_sample = smp;
        if (eob) begin
            awaiting_first = 1'b1;
            blocks++;
        end
    endfunction

    task check_result(logic signed [SW-1:0] smp, logic last, logic ovf);
        t_word w;
        words_out++;
        if (pending.size() == 0) begin
            report($sformatf("word %0d arrived with nothing outstanding", smp));
            return;
        end
        w = pending.pop_front();
        if (smp !== w.sample) begin
            report($sformatf("sample_out %0d, predicted %0d", smp, w.sample));
        end
        if (last !== w.last) begin
            report($sformatf("last_of_run %b, predicted %b", last, w.last));
        end
        if (ovf !== w.ovf) begin
            report($sformatf("overflow_flag %b, predicted %b", ovf, w.ovf));
        end
    endtask

endclass

module linear_interp_rate_converter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lirc_pkg::*;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 16;
    localparam int MAX_OUT    = 8;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 9;

    // Writes to the two spare register indexes must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [STEP_W-1:0]          STEP_MAX   = 16'hFFFF;

    // Every word that needs the front end's phase update yields results only after that
    // update, so once the last result is in nothing is left inside; this is a margin only.
    localparam int SETTLE_CYCLES = 64;
    // Length of the deliberate back-pressure episode on the output side.
    localparam int LONG_HOLD     = 800;
    // A correct run never goes this long without a word moving on either side: the longest
    // honest gap is the long hold above.
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_WORDS  = 450;
    // The tail of the random part runs with neither side idling.
    localparam int CALM_TAIL     = 80;
    localparam int WORDS_PER_SETTING = 36;
    localparam int TABLE_LEN     = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [STEP_W-1:0]     i_cfg_data;

    lirc_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_if ();
    lirc_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_if ();

    linear_interp_rate_converter #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .STEP_WIDTH   (STEP_W),
        .MAX_OUTPUTS  (MAX_OUT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    resample_scoreboard #(SAMPLE_W, STEP_W, MAX_OUT) sb;

    // Idle burst odds: a burst starts on a given word or cycle with probability 1/odds, and
    // zero switches idling off. The sender and the receiver each have their own setting.
    int gap_odds      = 0;
    int stall_odds    = 0;
    // The stimulus asks for a long hold-off by bumping hold_requests; the receiver serves it.
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int random_words  = 0;
    int settings_used = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: checks every word taken and decides ready for the next cycle. The long hold
    // is counted down here, so the sender keeps offering words until the block pushes back.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                sb.check_result(out_if.sample_out, out_if.last_of_run, out_if.overflow_flag);
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                stall_left = $urandom_range(0, 10);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Any accepted word on either side restarts the watchdog count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Loads both step registers, and optionally pokes the spare indexes with random data.
    // The write enable stays high across the sequence so that it is only driven once per
    // edge, and the scoreboard follows each write as the block should.
    task automatic load_steps(input logic [STEP_W-1:0] istep, input logic [STEP_W-1:0] ostep,
                              input bit spare);
        logic [STEP_W-1:0] junk;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INPUT_STEP;
        i_cfg_data <= istep;
        @(posedge i_clk);
        sb.set_step(CFG_INPUT_STEP, istep);
        i_cfg_idx  <= CFG_OUTPUT_STEP;
        i_cfg_data <= ostep;
        @(posedge i_clk);
        sb.set_step(CFG_OUTPUT_STEP, ostep);
        if (spare) begin
            junk = STEP_W'($urandom);
            i_cfg_idx  <= CFG_SPARE_A;
            i_cfg_data <= junk;
            @(posedge i_clk);
            sb.set_step(CFG_SPARE_A, junk);
            junk = STEP_W'($urandom);
            i_cfg_idx  <= CFG_SPARE_B;
            i_cfg_data <= junk;
            @(posedge i_clk);
            sb.set_step(CFG_SPARE_B, junk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Offers one word, after an idle burst now and then, and waits for the handshake.
    // Valid is left high on return so back-to-back words need no second assignment.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic eob);
        int gap;
        gap = 0;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 11);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_in    <= smp;
        in_if.end_of_block <= eob;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(smp, eob);
    endtask

    // Stops offering, waits for every predicted word, then lets the front end go quiet.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly uniform samples, with the full-scale and near-zero values often enough that
    // steps between opposite extremes turn up regularly.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'($urandom_range(0, 3) - 2);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned step_in_tab  [TABLE_LEN] = '{1, 2, 3, 160, 147, 7, 1, 65535, 65535, 40, 0, 5};
        int unsigned step_out_tab [TABLE_LEN] = '{1, 3, 2, 147, 160, 5, 65535, 65535, 1, 3, 0, 7};
        logic [STEP_W-1:0] istep, ostep;
        int  setting_no, words_here, len, i;
        bit  leave_open, paused;

        sb = new();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_INPUT_STEP;
        i_cfg_data         <= '0;
        in_if.valid        <= 1'b0;
        in_if.sample_in    <= '0;
        in_if.end_of_block <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Up to four outputs per sample with full-scale swings in both directions,
        // then a block of a single sample, which must come straight through.
        load_steps(16'd4, 16'd1, 1'b1);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(-16'sd1, 1'b1);
        send_word(16'sd12345, 1'b1);
        drain();

        // Output grid coarser than the input grid: most samples produce nothing at all.
        load_steps(16'd1, 16'd3, 1'b0);
        send_word(16'sd100, 1'b0);
        send_word(-16'sd100, 1'b0);
        send_word(16'sd5, 1'b0);
        send_word(-16'sd5, 1'b1);
        drain();

        // Widest input step against the finest output step: far more outputs are due than
        // the block may emit, so the surplus is dropped and every interpolated word carries the flag.
        load_steps(STEP_MAX, 16'd1, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(SAMPLE_MIN, 1'b1);
        drain();

        // Both steps written as zero, which the block must treat as one.
        load_steps(16'd0, 16'd0, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(16'sd1, 1'b1);
        drain();

        // Steps changed in the middle of a block: the stored phase carries over.
        load_steps(16'd5, 16'd2, 1'b0);
        send_word(16'sd1000, 1'b0);
        send_word(-16'sd2000, 1'b0);
        drain();
        load_steps(16'd3, 16'd7, 1'b1);
        send_word(16'sd3000, 1'b0);
        send_word(-16'sd4000, 1'b0);
        send_word(16'sd7, 1'b1);
        drain();

        // Random part: a run of blocks under each step setting, the table first and then
        // random ratios, mostly small with an occasional wide one. Some settings end with
        // the block still open, so the next setting lands mid-block.
        setting_no = 0;
        paused     = 1'b0;
        while (random_words < RANDOM_WORDS) begin
            if (setting_no < TABLE_LEN) begin
                istep = STEP_W'(step_in_tab[setting_no]);
                ostep = STEP_W'(step_out_tab[setting_no]);
            end else if ($urandom_range(0, 3) == 0) begin
                istep = STEP_W'($urandom_range(1, 65535));
                ostep = STEP_W'($urandom_range(1, 65535));
            end else begin
                istep = STEP_W'($urandom_range(1, 64));
                ostep = STEP_W'($urandom_range(1, 64));
            end
            load_steps(istep, ostep, setting_no % 4 == 0);
            words_here = 0;
            while (words_here < WORDS_PER_SETTING && random_words < RANDOM_WORDS) begin
                // Idling comes and goes per block, with calm stretches in between.
                case ($urandom_range(0, 2))
                    0: begin gap_odds = 0; stall_odds = 0; end
                    1: begin gap_odds = 4; stall_odds = 6; end
                    default: begin gap_odds = 2; stall_odds = 3; end
                endcase
                if (random_words >= RANDOM_WORDS - CALM_TAIL) begin
                    gap_odds   = 0;
                    stall_odds = 0;
                end
                // With steps three to two every word makes output, so a long hold-off here
                // backs the block up until it refuses input.
                if (setting_no == 2 && words_here == 0) hold_requests++;
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
                leave_open = (words_here + len >= WORDS_PER_SETTING) &&
                             ($urandom_range(0, 2) == 0);
                for (i = 0; i < len; i++) begin
                    // Once, the sender stops mid-block until every word has come out.
                    if (setting_no == 4 && !paused && i == len / 2 && i != 0) begin
                        paused = 1'b1;
                        drain();
                    end
                    send_word(pick_sample(), (i == len - 1) && !leave_open);
                end
                words_here   += len;
                random_words += len;
            end
            drain();
            setting_no++;
        end

        $display("covered %0d input words (%0d blocks) over %0d step settings, %0d words out",
                 sb.words_in, sb.blocks, settings_used, sb.words_out);
        $display("%0d input words hit the output limit, %0d produced no word",
                 sb.overflow_inputs, sb.silent_inputs);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
